// ===== design/ctrr_pkg.sv =====
package ctrr_pkg;

  localparam int unsigned FRAME_DATA_BYTES = 7;
  localparam int unsigned FIRST_DATA_BYTES = 6;
  localparam int unsigned NEXT_DATA_BYTES  = 7;

  localparam int unsigned LEN_W = 12;
  localparam int unsigned CNT_W = 3;

  // Frame kinds carried in the high nibble of the PCI byte
  localparam logic [3:0] KIND_SINGLE      = 4'h0;
  localparam logic [3:0] KIND_FIRST       = 4'h1;
  localparam logic [3:0] KIND_CONSECUTIVE = 4'h2;

  localparam logic [3:0]       MAX_SINGLE_LEN = 4'd7;
  localparam logic [LEN_W-1:0] MIN_FIRST_LEN  = 12'd8;

  // One frame's worth of output beats, handed from front to back
  typedef struct packed {
    logic [FRAME_DATA_BYTES-1:0][7:0] data;
    logic [CNT_W-1:0]                 cnt;      // number of beats, 1..7
    logic [LEN_W-1:0]                 base_pos;
    logic [LEN_W-1:0]                 msg_len;
    logic                             last_en;  // final beat closes the message
    logic                             err;
  } ctrr_job_t;

endpackage

// ===== design/ctrr_front.sv =====
module ctrr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          pci_byte_i,
  input  logic [7:0]          frame_byte1_i,
  input  logic [7:0]          frame_byte2_i,
  input  logic [7:0]          frame_byte3_i,
  input  logic [7:0]          frame_byte4_i,
  input  logic [7:0]          frame_byte5_i,
  input  logic [7:0]          frame_byte6_i,
  input  logic [7:0]          frame_byte7_i,
  input  logic                full_i,
  output logic                push_o,
  output ctrr_pkg::ctrr_job_t job_o
);
  import ctrr_pkg::*;

  logic             receiving_q, receiving_d;
  logic [LEN_W-1:0] total_q, total_d;
  logic [LEN_W-1:0] remaining_q, remaining_d;
  logic [LEN_W-1:0] received_q, received_d;

  logic [7:0]       frame [1:FRAME_DATA_BYTES];
  logic [3:0]       kind;
  logic [3:0]       nib;
  logic [LEN_W-1:0] ff_len;
  logic [CNT_W-1:0] cf_cnt;
  logic             accept;
  logic             emit;

  assign frame[1] = frame_byte1_i;
  assign frame[2] = frame_byte2_i;
  assign frame[3] = frame_byte3_i;
  assign frame[4] = frame_byte4_i;
  assign frame[5] = frame_byte5_i;
  assign frame[6] = frame_byte6_i;
  assign frame[7] = frame_byte7_i;

  assign kind   = pci_byte_i[7:4];
  assign nib    = pci_byte_i[3:0];
  assign ff_len = {nib, frame_byte1_i};
  assign cf_cnt = (remaining_q < LEN_W'(NEXT_DATA_BYTES)) ? remaining_q[CNT_W-1:0]
                                                          : CNT_W'(NEXT_DATA_BYTES);

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && emit;

  always_comb begin
    receiving_d = receiving_q;
    total_d     = total_q;
    remaining_d = remaining_q;
    received_d  = received_q;
    emit        = 1'b0;
    job_o       = '0;
    case (kind)
      KIND_SINGLE: begin
        emit          = 1'b1;
        job_o.msg_len = {8'd0, nib};
        if (nib == 4'd0 || nib > MAX_SINGLE_LEN) begin
          job_o.cnt = CNT_W'(1);
          job_o.err = 1'b1;
        end else begin
          receiving_d   = 1'b0;
          job_o.cnt     = nib[CNT_W-1:0];
          job_o.last_en = 1'b1;
          for (int i = 0; i < FRAME_DATA_BYTES; i++) begin
            job_o.data[i] = frame[i+1];
          end
        end
      end
      KIND_FIRST: begin
        emit          = 1'b1;
        job_o.msg_len = ff_len;
        if (ff_len < MIN_FIRST_LEN) begin
          job_o.cnt = CNT_W'(1);
          job_o.err = 1'b1;
        end else begin
          receiving_d = 1'b1;
          total_d     = ff_len;
          received_d  = LEN_W'(FIRST_DATA_BYTES);
          remaining_d = ff_len - LEN_W'(FIRST_DATA_BYTES);
          job_o.cnt   = CNT_W'(FIRST_DATA_BYTES);
          for (int i = 0; i < FIRST_DATA_BYTES; i++) begin
            job_o.data[i] = frame[i+2];
          end
        end
      end
      KIND_CONSECUTIVE: begin
        if (receiving_q && cf_cnt != '0) begin
          emit           = 1'b1;
          job_o.cnt      = cf_cnt;
          job_o.base_pos = received_q;
          job_o.msg_len  = total_q;
          job_o.last_en  = (remaining_q == LEN_W'(cf_cnt));
          for (int i = 0; i < FRAME_DATA_BYTES; i++) begin
            job_o.data[i] = frame[i+1];
          end
        end
        if (receiving_q) begin
          received_d  = received_q + LEN_W'(cf_cnt);
          remaining_d = remaining_q - LEN_W'(cf_cnt);
          if (remaining_d == '0) begin
            receiving_d = 1'b0;
          end
        end
      end
      default: begin
        // flow control and unknown kinds: drop
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      total_q     <= '0;
      remaining_q <= '0;
      received_q  <= '0;
    end else if (accept) begin
      receiving_q <= receiving_d;
      total_q     <= total_d;
      remaining_q <= remaining_d;
      received_q  <= received_d;
    end
  end

endmodule

// ===== design/ctrr_queue.sv =====
module ctrr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ctrr_pkg::ctrr_job_t job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ctrr_pkg::ctrr_job_t job_o
);
  import ctrr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(DEPTH + 1);

  ctrr_job_t         mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/ctrr_back.sv =====
module ctrr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  ctrr_pkg::ctrr_job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          data_byte_o,
  output logic [11:0]         byte_position_o,
  output logic [11:0]         message_length_o,
  output logic                last_of_message_o,
  output logic                length_error_o
);
  import ctrr_pkg::*;

  logic [CNT_W-1:0] idx_q;
  logic             out_valid_q;
  logic [7:0]       data_q;
  logic [LEN_W-1:0] pos_q, len_q;
  logic             last_q, err_q;
  logic             load;
  logic             final_beat;

  assign load       = job_valid_i && (!out_valid_q || !out_stall_i);
  assign final_beat = (idx_q == job_i.cnt - 1'b1);
  assign pop_o      = load && final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= final_beat ? '0 : idx_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled, advance on load
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= job_i.data[idx_q];
      pos_q  <= job_i.base_pos + LEN_W'(idx_q);
      len_q  <= job_i.msg_len;
      last_q <= job_i.last_en && final_beat;
      err_q  <= job_i.err;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = data_q;
  assign byte_position_o   = pos_q;
  assign message_length_o  = len_q;
  assign last_of_message_o = last_q;
  assign length_error_o    = err_q;

endmodule

// ===== design/can_transport_receive_reassembly.sv =====
// The first beat of a frame passes through the job queue and then the output register.
// Output: one beat per cycle while out_stall_i is low; a frame's job stays at the queue
// head until its 1 to 7 beats (its byte count) are loaded; frames that yield nothing are dropped.
// Input takes a frame every cycle while the job queue (QUEUE_DEPTH frames) has room.
// Reset clears the reassembly state (idle, all counts zero), the queue and output valid.
module can_transport_receive_reassembly #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pci_byte_i,
  input  logic [7:0]  frame_byte1_i,
  input  logic [7:0]  frame_byte2_i,
  input  logic [7:0]  frame_byte3_i,
  input  logic [7:0]  frame_byte4_i,
  input  logic [7:0]  frame_byte5_i,
  input  logic [7:0]  frame_byte6_i,
  input  logic [7:0]  frame_byte7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [11:0] byte_position_o,
  output logic [11:0] message_length_o,
  output logic        last_of_message_o,
  output logic        length_error_o
);
  import ctrr_pkg::*;

  ctrr_job_t push_job, head_job;
  logic      push, full, head_valid, pop;

  ctrr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pci_byte_i    (pci_byte_i),
    .frame_byte1_i (frame_byte1_i),
    .frame_byte2_i (frame_byte2_i),
    .frame_byte3_i (frame_byte3_i),
    .frame_byte4_i (frame_byte4_i),
    .frame_byte5_i (frame_byte5_i),
    .frame_byte6_i (frame_byte6_i),
    .frame_byte7_i (frame_byte7_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  ctrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  ctrr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (head_valid),
    .job_i             (head_job),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .data_byte_o       (data_byte_o),
    .byte_position_o   (byte_position_o),
    .message_length_o  (message_length_o),
    .last_of_message_o (last_of_message_o),
    .length_error_o    (length_error_o)
  );

  a_last_not_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_message_o) |-> !length_error_o)
    else $error("last beat flagged as length error");

  a_last_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_message_o) |-> (byte_position_o == message_length_o - 12'd1))
    else $error("last beat not at final position");

  a_error_beat_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && length_error_o) |-> (data_byte_o == 8'd0 && byte_position_o == 12'd0))
    else $error("error beat carries data");

  a_position_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !length_error_o) |-> (byte_position_o < message_length_o))
    else $error("beat position beyond message length");

endmodule

// ===== sim/reassembly_checker.sv =====
`timescale 1ns / 100ps

module reassembly_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  pci_byte_i,
  input  logic [7:0]  frame_byte1_i,
  input  logic [7:0]  frame_byte2_i,
  input  logic [7:0]  frame_byte3_i,
  input  logic [7:0]  frame_byte4_i,
  input  logic [7:0]  frame_byte5_i,
  input  logic [7:0]  frame_byte6_i,
  input  logic [7:0]  frame_byte7_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] byte_position_i,
  input  logic [11:0] message_length_i,
  input  logic        last_of_message_i,
  input  logic        length_error_i,
  output int          fail_count_o,
  output int          pending_o
);
  import ctrr_pkg::*;

  typedef struct packed {
    logic [7:0]       data;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             err;
  } rx_beat_t;

  // Reassembly state of the predictor
  logic             receiving;
  logic [LEN_W-1:0] total_len;
  logic [LEN_W-1:0] bytes_left;
  logic [LEN_W-1:0] bytes_done;

  rx_beat_t expected_beats[$];
  rx_beat_t got;
  rx_beat_t want;
  int       mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic predict_frame(input logic [7:0] pci, input logic [6:0][7:0] body);
    logic [3:0]       nib;
    logic [LEN_W-1:0] len;
    int unsigned      cnt;
    nib = pci[3:0];
    case (pci[7:4])
      KIND_SINGLE: begin
        if (nib == 4'd0 || nib > MAX_SINGLE_LEN) begin
          expected_beats.push_back(rx_beat_t'{8'h00, LEN_W'(0), LEN_W'(nib), 1'b0, 1'b1});
        end else begin
          // abandon any multi-frame message in progress
          receiving = 1'b0;
          for (int i = 0; i < nib; i++) begin
            expected_beats.push_back(rx_beat_t'{body[i], LEN_W'(i), LEN_W'(nib),
                                                i == nib - 1, 1'b0});
          end
        end
      end
      KIND_FIRST: begin
        len = {nib, body[0]};
        if (len < MIN_FIRST_LEN) begin
          expected_beats.push_back(rx_beat_t'{8'h00, LEN_W'(0), len, 1'b0, 1'b1});
        end else begin
          total_len  = len;
          bytes_done = LEN_W'(FIRST_DATA_BYTES);
          bytes_left = len - LEN_W'(FIRST_DATA_BYTES);
          receiving  = 1'b1;
          for (int i = 0; i < FIRST_DATA_BYTES; i++) begin
            expected_beats.push_back(rx_beat_t'{body[i+1], LEN_W'(i), len, 1'b0, 1'b0});
          end
        end
      end
      KIND_CONSECUTIVE: begin
        if (receiving) begin
          cnt = (bytes_left < NEXT_DATA_BYTES) ? bytes_left : NEXT_DATA_BYTES;
          for (int i = 0; i < cnt; i++) begin
            expected_beats.push_back(rx_beat_t'{body[i], bytes_done + LEN_W'(i), total_len,
                                                (i == cnt - 1) && (bytes_left == cnt),
                                                1'b0});
          end
          bytes_done = bytes_done + LEN_W'(cnt);
          bytes_left = bytes_left - LEN_W'(cnt);
          if (bytes_left == '0) receiving = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving  = 1'b0;
      total_len  = '0;
      bytes_left = '0;
      bytes_done = '0;
      expected_beats.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_frame(pci_byte_i, {frame_byte7_i, frame_byte6_i, frame_byte5_i,
                                   frame_byte4_i, frame_byte3_i, frame_byte2_i,
                                   frame_byte1_i});
      end
      if (out_valid_i && !out_stall_i) begin
        got = {data_byte_i, byte_position_i, message_length_i, last_of_message_i,
               length_error_i};
        if (expected_beats.size() == 0) begin
          $display({"%0t ns: unexpected beat: expected no beat, ",
                    "actual data %h pos %0d len %0d last %b err %b"},
                   $time, got.data, got.pos, got.len, got.last, got.err);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display({"%0t ns: beat mismatch: expected data %h pos %0d len %0d last %b ",
                      "err %b, actual data %h pos %0d len %0d last %b err %b"},
                     $time, want.data, want.pos, want.len, want.last, want.err,
                     got.data, got.pos, got.len, got.last, got.err);
            mismatches++;
          end
        end
      end
      pending_o <= expected_beats.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ctrr_pkg::*;

  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         FRAME_TARGET   = 460;
  localparam logic [3:0] KIND_FLOW      = 4'h3;

  typedef logic [6:0][7:0] frame_body_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pci_byte_i    = '0;
  logic [7:0]  frame_byte1_i = '0;
  logic [7:0]  frame_byte2_i = '0;
  logic [7:0]  frame_byte3_i = '0;
  logic [7:0]  frame_byte4_i = '0;
  logic [7:0]  frame_byte5_i = '0;
  logic [7:0]  frame_byte6_i = '0;
  logic [7:0]  frame_byte7_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  data_byte_o;
  logic [11:0] byte_position_o;
  logic [11:0] message_length_o;
  logic        last_of_message_o;
  logic        length_error_o;

  int fail_count;
  int pending;
  int frames_sent = 0;
  int idle_run    = 0;
  bit quiet       = 1'b0;

  initial forever #10 clk_i = ~clk_i;

  can_transport_receive_reassembly dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pci_byte_i        (pci_byte_i),
    .frame_byte1_i     (frame_byte1_i),
    .frame_byte2_i     (frame_byte2_i),
    .frame_byte3_i     (frame_byte3_i),
    .frame_byte4_i     (frame_byte4_i),
    .frame_byte5_i     (frame_byte5_i),
    .frame_byte6_i     (frame_byte6_i),
    .frame_byte7_i     (frame_byte7_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .data_byte_o       (data_byte_o),
    .byte_position_o   (byte_position_o),
    .message_length_o  (message_length_o),
    .last_of_message_o (last_of_message_o),
    .length_error_o    (length_error_o)
  );

  reassembly_checker beat_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .pci_byte_i        (pci_byte_i),
    .frame_byte1_i     (frame_byte1_i),
    .frame_byte2_i     (frame_byte2_i),
    .frame_byte3_i     (frame_byte3_i),
    .frame_byte4_i     (frame_byte4_i),
    .frame_byte5_i     (frame_byte5_i),
    .frame_byte6_i     (frame_byte6_i),
    .frame_byte7_i     (frame_byte7_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .data_byte_i       (data_byte_o),
    .byte_position_i   (byte_position_o),
    .message_length_i  (message_length_o),
    .last_of_message_i (last_of_message_o),
    .length_error_i    (length_error_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Stall the output side now and then, except during the quiet stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic frame_body_t random_body();
    logic [55:0] bits;
    bits = 56'({$urandom(), $urandom()});
    return bits;
  endfunction

  // Present one frame and hold it until the beat is taken
  task automatic send_frame(input logic [7:0] pci, input frame_body_t body);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pci_byte_i    <= pci;
    frame_byte1_i <= body[0];
    frame_byte2_i <= body[1];
    frame_byte3_i <= body[2];
    frame_byte4_i <= body[3];
    frame_byte5_i <= body[4];
    frame_byte6_i <= body[5];
    frame_byte7_i <= body[6];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (pci[7:4] <= KIND_CONSECUTIVE) frames_sent++;
  endtask

  task automatic send_first(input logic [LEN_W-1:0] len, input frame_body_t body);
    body[0] = len[7:0];
    send_frame({KIND_FIRST, len[11:8]}, body);
  endtask

  // Frames that the block ignores, rejects, or that break a message apart
  task automatic send_noise();
    frame_body_t body;
    int          pick;
    body = random_body();
    pick = $urandom_range(0, 4);
    case (pick)
      0: send_frame(8'($urandom()), body);
      1: send_frame({4'($urandom_range(KIND_FLOW, 15)), 4'($urandom())}, body);
      2: send_frame({KIND_SINGLE, ($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(8, 15)))},
                    body);
      3: send_first(LEN_W'($urandom_range(0, MIN_FIRST_LEN - 1)), body);
      default: send_frame({KIND_CONSECUTIVE, 4'($urandom())}, body);
    endcase
  endtask

  task automatic send_message();
    logic [LEN_W-1:0] len;
    logic [3:0]       seq;
    int               r;
    int               cf_count;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_frame({KIND_SINGLE, 4'($urandom_range(1, MAX_SINGLE_LEN))}, random_body());
    end else begin
      if (r < 85)      len = LEN_W'($urandom_range(MIN_FIRST_LEN, 48));
      else if (r < 97) len = LEN_W'($urandom_range(49, 200));
      else             len = LEN_W'($urandom_range(201, 600));
      send_first(len, random_body());
      cf_count = (len - FIRST_DATA_BYTES + NEXT_DATA_BYTES - 1) / NEXT_DATA_BYTES;
      seq = 4'd1;
      for (int n = 0; n < cf_count; n++) begin
        // drop the rest of the message now and then
        if ($urandom_range(0, 99) < 3) break;
        if ($urandom_range(0, 99) < 5) send_noise();
        send_frame({KIND_CONSECUTIVE, seq}, random_body());
        seq++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame({KIND_SINGLE, 4'd0}, '1);
    send_frame({KIND_SINGLE, 4'd8}, '0);
    send_frame({KIND_SINGLE, 4'hF}, '1);
    send_frame({KIND_SINGLE, 4'd1}, '1);
    send_frame({KIND_SINGLE, MAX_SINGLE_LEN}, '0);
    send_frame({KIND_SINGLE, MAX_SINGLE_LEN}, '1);
    send_first(12'd7, '1);
    send_first(12'd0, '0);
    send_frame({KIND_CONSECUTIVE, 4'd1}, '1);      // no message open
    send_first(MIN_FIRST_LEN, '1);
    send_frame({KIND_CONSECUTIVE, 4'd1}, '0);
    send_frame({KIND_CONSECUTIVE, 4'hF}, '1);
    send_first(12'hFFF, '0);
    send_frame({KIND_CONSECUTIVE, 4'd1}, '1);
    send_first(12'd20, '1);                        // restart the open message
    send_frame({KIND_CONSECUTIVE, 4'd1}, random_body());
    send_frame({KIND_FLOW, 4'd0}, '1);
    send_frame(8'hFF, '1);
    send_frame({KIND_SINGLE, 4'd0}, '0);           // rejected, message stays open
    send_first(12'd5, '1);                         // rejected, message stays open
    send_frame({KIND_CONSECUTIVE, 4'd2}, '1);      // exactly seven bytes left
    send_first(12'd30, random_body());
    send_frame({KIND_CONSECUTIVE, 4'd1}, random_body());
    send_frame({KIND_SINGLE, 4'd3}, random_body()); // abandons the open message
    send_frame({KIND_CONSECUTIVE, 4'd2}, random_body());

    while (frames_sent < FRAME_TARGET) begin
      quiet <= (frames_sent >= 180 && frames_sent < 300);
      if ($urandom_range(0, 99) < 12) send_noise();
      else send_message();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ctrr_pkg.sv
design/ctrr_front.sv
design/ctrr_queue.sv
design/ctrr_back.sv
design/can_transport_receive_reassembly.sv
sim/reassembly_checker.sv
sim/tb_top.sv
